>>> rtl/core/tmnl_pkg.sv
// Shared types and constants of the tiled mesh neighbor lookup.
// Used by every module under rtl/core; depends on nothing else.
package tmnl_pkg;

   localparam int MAX_TILES_AXIS = 32;
   localparam int MAX_CELLS_AXIS = 128;
   localparam int MAX_MATERIALS  = 16384;

   localparam int TILE_W  = $clog2(MAX_TILES_AXIS);                  // tile index
   localparam int NT_W    = TILE_W + 1;                               // tile count
   localparam int CELL_W  = $clog2(MAX_CELLS_AXIS);                   // cell coordinate
   localparam int NC_W    = CELL_W + 1;                               // cell count
   localparam int MAT_W   = $clog2(MAX_MATERIALS);                    // material number
   localparam int CNT_W   = MAT_W + 1;                                // material count
   localparam int FLAG_W  = 2 * TILE_W;                               // flag address
   localparam int ACC_W   = NC_W + TILE_W;                            // cells-per-tile sum
   localparam int DCNT_W  = $clog2(MAT_W + 1);                        // divider steps

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 15;

   localparam logic [CSR_IDX_W-1:0] CSR_DIM       = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CELLS_X   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_CELLS_Y   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_TILES_X   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_TILES_Y   = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_MAT_COUNT = 3'd5;

   localparam logic [2:0] OP_QUERY   = 3'd0;
   localparam logic [2:0] OP_WR_X    = 3'd1;
   localparam logic [2:0] OP_WR_Y    = 3'd2;
   localparam logic [2:0] OP_WR_FLAG = 3'd3;
   localparam logic [2:0] OP_WR_MAT  = 3'd4;

   localparam logic [2:0] DIR_XN = 3'd0;
   localparam logic [2:0] DIR_XP = 3'd1;
   localparam logic [2:0] DIR_YN = 3'd2;
   localparam logic [2:0] DIR_YP = 3'd3;

   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_MAT_RANGE = 2'd1;
   localparam logic [1:0] ST_BAD_DIR   = 2'd2;
   localparam logic [1:0] ST_WR_RANGE  = 2'd3;

   localparam logic [1:0] KIND_BOUNDARY = 2'd0;
   localparam logic [1:0] KIND_ALBEDO   = 2'd1;
   localparam logic [1:0] KIND_MATERIAL = 2'd2;

   typedef struct packed {
      logic [2:0]       operation;
      logic [MAT_W-1:0] index;
      logic [MAT_W-1:0] value;
      logic [2:0]       direction;
   } req_type;

   typedef struct packed {
      logic [1:0]        status;
      logic [1:0]        neighbor_kind;
      logic [1:0]        boundary_side;
      logic [MAT_W-1:0]  neighbor_material;
      logic [TILE_W-1:0] neighbor_tile_x;
      logic [TILE_W-1:0] neighbor_tile_y;
   } rsp_type;

   typedef struct packed {
      logic [1:0]       dimension_count;
      logic [7:0]       cells_x;
      logic [7:0]       cells_y;
      logic [5:0]       tiles_x;
      logic [5:0]       tiles_y;
      logic [CNT_W-1:0] material_count;
   } cfg_type;

   // controller -> datapath
   typedef struct packed {
      logic load;
      logic div_start_x;
      logic take_x;
      logic take_y;
      logic step;
      logic walk_rd;
      logic walk_cmp;
      logic flag_rd;
      logic flag_chk;
      logic srch_rd;
      logic srch_cmp;
      logic srch_end;
      logic emit;
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic early;
      logic div_busy;
      logic edge_hit;
      logic walk_stop;
      logic axis_y;
      logic two_d;
      logic flag_mat;
      logic srch_done;
   } stat_type;

endpackage

>>> rtl/core/tiled_mesh_neighbor_lookup.sv
// Tiled mesh neighbor lookup: configuration registers, output register and
// the controller/datapath pair. Depends on tmnl_pkg, tmnl_ctrl and tmnl_dp.
//
// The block holds the tile layout of a 1D or 2D structured mesh and answers
// neighbor queries. Every transaction on req gives exactly one transaction
// on rsp. Writes (cells per tile, tile flag, material table entry) and
// rejected queries skip the query steps. A query reads the material table,
// then runs two serial divisions to unravel the flat cell index. Unless the
// cell is on the mesh edge, it walks the cells-per-tile tables tile by tile
// along x and, in 2D, along y, reads the tile flag, and for a material tile
// runs a binary search over the table one probe at a time. At 32 tiles per
// axis and 16384 materials the tile walks and the single table read port
// set the worst case. One transaction is processed at a time, but a new
// one is taken while the previous result still waits in the rsp register.
// CSR writes take effect at once and must be made while idle.
module tiled_mesh_neighbor_lookup (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  tmnl_pkg::req_type               req_data,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output tmnl_pkg::rsp_type               rsp_data,
   input  logic                            csr_we,
   input  logic [tmnl_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [tmnl_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import tmnl_pkg::*;

   cfg_type  cfg_ff;
   logic     rsp_valid_ff;
   rsp_type  rsp_data_ff;
   cmd_type  cmd;
   stat_type stat;
   rsp_type  result;
   logic     out_free;

   // CSR file: reset to a 2D mesh of one cell, empty material table
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.dimension_count <= 2'd2;
         cfg_ff.cells_x         <= 8'd1;
         cfg_ff.cells_y         <= 8'd1;
         cfg_ff.tiles_x         <= 6'd1;
         cfg_ff.tiles_y         <= 6'd1;
         cfg_ff.material_count  <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_DIM:       cfg_ff.dimension_count <= csr_wdata[1:0];
            CSR_CELLS_X:   cfg_ff.cells_x         <= csr_wdata[7:0];
            CSR_CELLS_Y:   cfg_ff.cells_y         <= csr_wdata[7:0];
            CSR_TILES_X:   cfg_ff.tiles_x         <= csr_wdata[5:0];
            CSR_TILES_Y:   cfg_ff.tiles_y         <= csr_wdata[5:0];
            CSR_MAT_COUNT: cfg_ff.material_count  <= csr_wdata[CNT_W-1:0];
            default:       cfg_ff <= cfg_ff;  // drop writes to unused indexes
         endcase
      end
   end

   // result register: free when empty or being drained this cycle
   assign out_free = !rsp_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset)            rsp_valid_ff <= 1'b0;
      else if (cmd.emit)    rsp_valid_ff <= 1'b1;
      else if (rsp_ready)   rsp_valid_ff <= 1'b0;
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) rsp_data_ff <= result;  // hold until taken
   end

   tmnl_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .out_free  (out_free),
      .stat      (stat),
      .cmd       (cmd)
   );

   tmnl_dp u_dp (
      .clock  (clock),
      .reset  (reset),
      .cfg    (cfg_ff),
      .req    (req_data),
      .cmd    (cmd),
      .stat   (stat),
      .result (result)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
endmodule

>>> rtl/core/tmnl_div.sv
// Bit-serial restoring divider: one quotient bit per cycle.
// Depends on tmnl_pkg.
module tmnl_div (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [tmnl_pkg::MAT_W-1:0] dividend,
   input  logic [7:0]                 divisor,
   output logic                       busy,
   output logic [tmnl_pkg::MAT_W-1:0] quot,
   output logic [7:0]                 rem
);
   import tmnl_pkg::*;

   logic              busy_ff;
   logic [DCNT_W-1:0] cnt_ff;
   logic [MAT_W-1:0]  quot_ff;
   logic [8:0]        rem_ff;
   logic [8:0]        trial;
   logic              fits;

   assign trial = {rem_ff[7:0], quot_ff[MAT_W-1]};
   assign fits  = trial >= {1'b0, divisor};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (start) begin
         busy_ff <= 1'b1;
         cnt_ff  <= DCNT_W'(MAT_W);
      end else if (busy_ff) begin
         cnt_ff  <= cnt_ff - 1'b1;
         busy_ff <= cnt_ff != DCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         quot_ff <= dividend;
         rem_ff  <= '0;
      end else if (busy_ff) begin
         quot_ff <= {quot_ff[MAT_W-2:0], fits};
         rem_ff  <= fits ? trial - {1'b0, divisor} : trial;
      end
   end

   assign busy = busy_ff;
   assign quot = quot_ff;
   assign rem  = rem_ff[7:0];
endmodule

>>> rtl/core/tmnl_dp.sv
// Datapath: layout memories, divider, tile walk and table search.
// Depends on tmnl_pkg and tmnl_div.
module tmnl_dp (
   input  logic               clock,
   input  logic               reset,
   input  tmnl_pkg::cfg_type  cfg,
   input  tmnl_pkg::req_type  req,
   input  tmnl_pkg::cmd_type  cmd,
   output tmnl_pkg::stat_type stat,
   output tmnl_pkg::rsp_type  result
);
   import tmnl_pkg::*;

   logic [7:0]       x_mem [MAX_TILES_AXIS];
   logic [7:0]       y_mem [MAX_TILES_AXIS];
   logic             flag_mem [MAX_TILES_AXIS * MAX_TILES_AXIS];
   logic [MAT_W-1:0] mat_mem [MAX_MATERIALS];

   logic [MAT_W-1:0]  mat_q_ff;
   logic [7:0]        xq_ff, yq_ff;
   logic              flag_q_ff;
   logic [2:0]        dir_ff;
   logic [CELL_W-1:0] x_ff, y_ff;
   logic [TILE_W-1:0] t_ff;
   logic [ACC_W-1:0]  acc_ff;
   logic              axis_ff;
   logic              div_y_ff;
   logic [CNT_W-1:0]  lo_ff, hi_ff, key_ff;
   rsp_type           res_ff;

   logic             two_d;
   logic [NC_W-1:0]  nx, ny;
   logic [NT_W-1:0]  ntx, nty, lim;
   logic [CNT_W-1:0] count, mid;
   logic             idx_oor, bad_dir, edge_hit, last, stop;
   logic [ACC_W-1:0] acc_in;
   logic [CELL_W-1:0] pos;
   logic [1:0]       load_status;
   logic [MAT_W-1:0] mat_addr, div_dvd;
   logic             div_busy;
   logic [MAT_W-1:0] div_quot;
   logic [7:0]       div_rem;

   // effective sizes: zero counts as one, large values saturate, 1D forces y to one
   always_comb begin
      two_d = cfg.dimension_count[1];
      nx = (cfg.cells_x == '0) ? NC_W'(1) :
           ({1'b0, cfg.cells_x} > 9'(MAX_CELLS_AXIS)) ? NC_W'(MAX_CELLS_AXIS) :
           NC_W'(cfg.cells_x);
      ny = !two_d ? NC_W'(1) : (cfg.cells_y == '0) ? NC_W'(1) :
           ({1'b0, cfg.cells_y} > 9'(MAX_CELLS_AXIS)) ? NC_W'(MAX_CELLS_AXIS) :
           NC_W'(cfg.cells_y);
      ntx = (cfg.tiles_x == '0) ? NT_W'(1) :
            ({1'b0, cfg.tiles_x} > 7'(MAX_TILES_AXIS)) ? NT_W'(MAX_TILES_AXIS) :
            NT_W'(cfg.tiles_x);
      nty = !two_d ? NT_W'(1) : (cfg.tiles_y == '0) ? NT_W'(1) :
            ({1'b0, cfg.tiles_y} > 7'(MAX_TILES_AXIS)) ? NT_W'(MAX_TILES_AXIS) :
            NT_W'(cfg.tiles_y);
      count = (cfg.material_count > CNT_W'(MAX_MATERIALS)) ? CNT_W'(MAX_MATERIALS) :
              cfg.material_count;
   end

   always_comb begin
      idx_oor = {1'b0, req.index} >= count;
      bad_dir = two_d ? (req.direction > DIR_YP) : (req.direction > DIR_XP);
      load_status = ST_OK;
      unique case (req.operation)
         OP_WR_X, OP_WR_Y: begin
            if ({1'b0, req.index} >= CNT_W'(MAX_TILES_AXIS)) load_status = ST_WR_RANGE;
         end
         OP_WR_FLAG: begin
            if ({1'b0, req.index} >= CNT_W'(MAX_TILES_AXIS * MAX_TILES_AXIS))
               load_status = ST_WR_RANGE;
         end
         OP_WR_MAT: begin
            if ({1'b0, req.index} >= CNT_W'(MAX_MATERIALS)) load_status = ST_WR_RANGE;
         end
         OP_QUERY: begin
            if (idx_oor)      load_status = ST_MAT_RANGE;
            else if (bad_dir) load_status = ST_BAD_DIR;
         end
         default: load_status = ST_OK;
      endcase
   end

   always_comb begin
      edge_hit = (dir_ff == DIR_XN && x_ff == '0) ||
                 (dir_ff == DIR_XP && NC_W'(x_ff) == nx - 1'b1) ||
                 (dir_ff == DIR_YN && y_ff == '0) ||
                 (dir_ff == DIR_YP && NC_W'(y_ff) == ny - 1'b1);
      lim    = axis_ff ? nty : ntx;
      pos    = axis_ff ? y_ff : x_ff;
      acc_in = acc_ff + ACC_W'(axis_ff ? yq_ff : xq_ff);
      last   = (NT_W'(t_ff) + 1'b1) >= lim;
      stop   = last || (acc_in > ACC_W'(pos));
      mid    = CNT_W'(({1'b0, lo_ff} + {1'b0, hi_ff}) >> 1);
      mat_addr = cmd.srch_rd ? mid[MAT_W-1:0] : req.index;
      div_dvd  = cmd.take_x ? div_quot : mat_q_ff;
   end

   tmnl_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start_x | cmd.take_x),
      .dividend (div_dvd),
      .divisor  (div_y_ff ? ny[7:0] : nx[7:0]),
      .busy     (div_busy),
      .quot     (div_quot),
      .rem      (div_rem)
   );

   // layout memories: write on accepted write transactions, read registered
   always_ff @(posedge clock) begin
      if (cmd.load && load_status == ST_OK) begin
         if (req.operation == OP_WR_X) x_mem[req.index[TILE_W-1:0]] <= req.value[7:0];
         if (req.operation == OP_WR_Y) y_mem[req.index[TILE_W-1:0]] <= req.value[7:0];
         if (req.operation == OP_WR_FLAG) flag_mem[req.index[FLAG_W-1:0]] <= req.value[0];
      end
      if (cmd.walk_rd) begin
         xq_ff <= x_mem[t_ff];
         yq_ff <= y_mem[t_ff];
      end
      if (cmd.flag_rd) flag_q_ff <= flag_mem[{res_ff.neighbor_tile_y, res_ff.neighbor_tile_x}];
   end

   always_ff @(posedge clock) begin
      if (cmd.load && load_status == ST_OK && req.operation == OP_WR_MAT)
         mat_mem[req.index] <= req.value;
      if (cmd.load || cmd.srch_rd) mat_q_ff <= mat_mem[mat_addr];
   end

   // divide by the x cell count first, then the quotient by the y cell count
   always_ff @(posedge clock) begin
      if (cmd.div_start_x) div_y_ff <= 1'b0;
      else if (cmd.take_x) div_y_ff <= 1'b1;
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         res_ff <= rsp_type'{status: load_status, default: '0};
         dir_ff <= req.direction;
      end
      if (cmd.take_x) x_ff <= div_rem[CELL_W-1:0];
      if (cmd.take_y) y_ff <= div_rem[CELL_W-1:0];
      if (cmd.step) begin
         t_ff    <= '0;
         acc_ff  <= '0;
         axis_ff <= 1'b0;
         if (edge_hit) begin
            res_ff.neighbor_kind <= KIND_BOUNDARY;
            res_ff.boundary_side <= dir_ff[1:0];
         end else begin
            priority if (dir_ff == DIR_XN) x_ff <= x_ff - 1'b1;
            else if (dir_ff == DIR_XP)     x_ff <= x_ff + 1'b1;
            else if (dir_ff == DIR_YN)     y_ff <= y_ff - 1'b1;
            else                           y_ff <= y_ff + 1'b1;
         end
      end
      if (cmd.walk_cmp) begin
         if (stop) begin
            if (axis_ff) res_ff.neighbor_tile_y <= t_ff;
            else         res_ff.neighbor_tile_x <= t_ff;
            t_ff    <= '0;
            acc_ff  <= '0;
            axis_ff <= 1'b1;
         end else begin
            t_ff   <= t_ff + 1'b1;
            acc_ff <= acc_in;
         end
      end
      if (cmd.flag_chk) begin
         res_ff.neighbor_kind <= flag_q_ff ? KIND_MATERIAL : KIND_ALBEDO;
         lo_ff  <= '0;
         hi_ff  <= count;
         key_ff <= CNT_W'(y_ff) * CNT_W'(nx) + CNT_W'(x_ff);
      end
      if (cmd.srch_cmp) begin
         if ({1'b0, mat_q_ff} < key_ff) lo_ff <= mid + 1'b1;
         else                           hi_ff <= mid;
      end
      if (cmd.srch_end) res_ff.neighbor_material <= lo_ff[MAT_W-1:0];
   end

   always_comb begin
      stat.early     = (req.operation != OP_QUERY) || idx_oor || bad_dir;
      stat.div_busy  = div_busy;
      stat.edge_hit  = edge_hit;
      stat.walk_stop = stop;
      stat.axis_y    = axis_ff;
      stat.two_d     = two_d;
      stat.flag_mat  = flag_q_ff;
      stat.srch_done = lo_ff >= hi_ff;
   end

   assign result = res_ff;
endmodule

>>> rtl/core/tmnl_ctrl.sv
// Controller state machine: sequences one transaction through the datapath.
// Depends on tmnl_pkg.
module tmnl_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic               out_free,
   input  tmnl_pkg::stat_type stat,
   output tmnl_pkg::cmd_type  cmd
);
   import tmnl_pkg::*;

   typedef enum logic [11:0] {
      S_IDLE  = 12'b0000_0000_0001,
      S_MREAD = 12'b0000_0000_0010,
      S_DIVX  = 12'b0000_0000_0100,
      S_DIVY  = 12'b0000_0000_1000,
      S_STEP  = 12'b0000_0001_0000,
      S_WRD   = 12'b0000_0010_0000,
      S_WCMP  = 12'b0000_0100_0000,
      S_FRD   = 12'b0000_1000_0000,
      S_FCHK  = 12'b0001_0000_0000,
      S_SRD   = 12'b0010_0000_0000,
      S_SCMP  = 12'b0100_0000_0000,
      S_DONE  = 12'b1000_0000_0000
   } state_type;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else       state_ff <= state_in;
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = stat.early ? S_DONE : S_MREAD;
            end
         end
         S_MREAD: begin
            cmd.div_start_x = 1'b1;
            state_in = S_DIVX;
         end
         S_DIVX: begin
            if (!stat.div_busy) begin
               cmd.take_x = 1'b1;
               state_in = S_DIVY;
            end
         end
         S_DIVY: begin
            if (!stat.div_busy) begin
               cmd.take_y = 1'b1;
               state_in = S_STEP;
            end
         end
         S_STEP: begin
            cmd.step = 1'b1;
            state_in = stat.edge_hit ? S_DONE : S_WRD;
         end
         S_WRD: begin
            cmd.walk_rd = 1'b1;
            state_in = S_WCMP;
         end
         S_WCMP: begin
            cmd.walk_cmp = 1'b1;
            if (stat.walk_stop && (stat.axis_y || !stat.two_d)) state_in = S_FRD;
            else                                                state_in = S_WRD;
         end
         S_FRD: begin
            cmd.flag_rd = 1'b1;
            state_in = S_FCHK;
         end
         S_FCHK: begin
            cmd.flag_chk = 1'b1;
            state_in = stat.flag_mat ? S_SRD : S_DONE;
         end
         S_SRD: begin
            if (stat.srch_done) begin
               cmd.srch_end = 1'b1;
               state_in = S_DONE;
            end else begin
               cmd.srch_rd = 1'b1;
               state_in = S_SCMP;
            end
         end
         S_SCMP: begin
            cmd.srch_cmp = 1'b1;
            state_in = S_SRD;
         end
         S_DONE: begin
            if (out_free) begin
               cmd.emit = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end
endmodule

>>> sim/tiled_mesh_neighbor_lookup_test.sv
// Self-checking testbench of the tiled mesh neighbor lookup: a scoreboard
// class predicts every rsp transaction; plain tasks drive req and the CSRs.
// Depends on tmnl_pkg and tiled_mesh_neighbor_lookup from rtl/core.

import tmnl_pkg::*;

class mesh_lookup_scoreboard;
   // Shadow registers and tables, kept in step with the block
   bit [1:0]         dim;
   bit [7:0]         cx, cy;
   bit [5:0]         tx, ty;
   bit [CNT_W-1:0]   mcount;
   bit [7:0]         x_span [MAX_TILES_AXIS];
   bit [7:0]         y_span [MAX_TILES_AXIS];
   bit               tile_mat [MAX_TILES_AXIS*MAX_TILES_AXIS];
   bit [MAT_W-1:0]   mat_cell [MAX_MATERIALS];
   rsp_type          pending_q [$];
   int               mismatches;
   int               checked;

   function new();
      dim = 2; cx = 1; cy = 1; tx = 1; ty = 1; mcount = 0;
      mismatches = 0; checked = 0;
   endfunction

   function void set_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] d);
      case (idx)
         CSR_DIM:       dim = d[1:0];
         CSR_CELLS_X:   cx = d[7:0];
         CSR_CELLS_Y:   cy = d[7:0];
         CSR_TILES_X:   tx = d[5:0];
         CSR_TILES_Y:   ty = d[5:0];
         CSR_MAT_COUNT: mcount = d;
         default: ;
      endcase
   endfunction

   function int clamp(int v, int hi);
      if (v == 0) return 1;
      return (v > hi) ? hi : v;
   endfunction

   // Effective sizes: zero counts as one, oversized saturates, 1D forces y to 1
   function void geometry(output int nx, output int ny, output int ntx,
                          output int nty, output int cnt);
      bit two_d;
      two_d = (dim >= 2);
      nx  = clamp(cx, MAX_CELLS_AXIS);
      ny  = two_d ? clamp(cy, MAX_CELLS_AXIS) : 1;
      ntx = clamp(tx, MAX_TILES_AXIS);
      nty = two_d ? clamp(ty, MAX_TILES_AXIS) : 1;
      cnt = (mcount > MAX_MATERIALS) ? MAX_MATERIALS : mcount;
   endfunction

   // Walk the running sum of cells per tile; stop at the last tile
   function int tile_of(bit y_axis, int n, int pos);
      int t, acc;
      t = 0; acc = 0;
      while (t + 1 < n) begin
         acc += y_axis ? y_span[t] : x_span[t];
         if (acc > pos) break;
         t++;
      end
      return t;
   endfunction

   // First table position whose cell index is not below the key
   function int first_not_below(int n, int key);
      int lo, hi, mid;
      lo = 0; hi = n;
      while (lo < hi) begin
         mid = lo + (hi - lo) / 2;
         if (int'(mat_cell[mid]) < key) lo = mid + 1;
         else hi = mid;
      end
      return lo;
   endfunction

   function rsp_type neighbor_of(req_type r);
      rsp_type e;
      int      nx, ny, ntx, nty, cnt, flat, x, y, tix, tiy;
      bit      two_d, at_edge;
      e = '0;
      case (r.operation)
         OP_WR_X:
            if (r.index >= MAX_TILES_AXIS) e.status = ST_WR_RANGE;
            else x_span[r.index] = r.value[7:0];
         OP_WR_Y:
            if (r.index >= MAX_TILES_AXIS) e.status = ST_WR_RANGE;
            else y_span[r.index] = r.value[7:0];
         OP_WR_FLAG:
            if (r.index >= MAX_TILES_AXIS*MAX_TILES_AXIS) e.status = ST_WR_RANGE;
            else tile_mat[r.index] = r.value[0];
         OP_WR_MAT:
            mat_cell[r.index] = r.value;
         OP_QUERY: begin
            geometry(nx, ny, ntx, nty, cnt);
            two_d = (dim >= 2);
            if (r.index >= cnt) begin
               e.status = ST_MAT_RANGE;
            end else if (r.direction > (two_d ? DIR_YP : DIR_XP)) begin
               e.status = ST_BAD_DIR;
            end else begin
               flat = mat_cell[r.index];
               x = flat % nx;
               y = (flat / nx) % ny;
               at_edge = (r.direction == DIR_XN && x == 0) ||
                         (r.direction == DIR_XP && x == nx - 1) ||
                         (r.direction == DIR_YN && y == 0) ||
                         (r.direction == DIR_YP && y == ny - 1);
               if (at_edge) begin
                  e.neighbor_kind = KIND_BOUNDARY;
                  e.boundary_side = r.direction[1:0];
               end else begin
                  case (r.direction)
                     DIR_XN:  x--;
                     DIR_XP:  x++;
                     DIR_YN:  y--;
                     default: y++;
                  endcase
                  tix = tile_of(1'b0, ntx, x);
                  tiy = two_d ? tile_of(1'b1, nty, y) : 0;
                  e.neighbor_tile_x = tix[TILE_W-1:0];
                  e.neighbor_tile_y = tiy[TILE_W-1:0];
                  if (tile_mat[tiy*MAX_TILES_AXIS + tix]) begin
                     e.neighbor_kind = KIND_MATERIAL;
                     e.neighbor_material = MAT_W'(first_not_below(cnt, x + y*nx));
                  end else begin
                     e.neighbor_kind = KIND_ALBEDO;
                  end
               end
            end
         end
         default: ;
      endcase
      return e;
   endfunction

   function void note_input(req_type r);
      pending_q.insert(pending_q.size(), neighbor_of(r));
   endfunction

   function void check_result(rsp_type got);
      rsp_type e;
      checked++;
      if (pending_q.size() == 0) begin
         mismatches++;
         if (mismatches <= 10) $display("unexpected rsp transaction %p", got);
         return;
      end
      e = pending_q.pop_front();
      if (got.status !== e.status || got.neighbor_kind !== e.neighbor_kind ||
          got.boundary_side !== e.boundary_side ||
          got.neighbor_material !== e.neighbor_material ||
          got.neighbor_tile_x !== e.neighbor_tile_x ||
          got.neighbor_tile_y !== e.neighbor_tile_y) begin
         mismatches++;
         if (mismatches <= 10) begin
            $display("mismatch on rsp %0d", checked);
            $display("  expected %p", e);
            $display("  actual   %p", got);
         end
      end
   endfunction
endclass

module tiled_mesh_neighbor_lookup_test;

   localparam int QUIET_LIMIT = 4000;   // cycles with no transaction at all
   localparam int HOLD_CYCLES = 400;    // long receiver hold-off
   localparam int DRAIN       = 250;    // about one slow query plus margin

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   req_type               req_data = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   rsp_type               rsp_data;
   logic                  csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   mesh_lookup_scoreboard sb = new();
   bit  no_idle = 1'b0;
   int  n_req = 0;
   int  n_rsp = 0;
   int  quiet = 0;
   int  n_phase = 0;

   tiled_mesh_neighbor_lookup u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Offer one transaction, with a random gap first unless no_idle is set, and hold it until taken.
   // Sample ready in mid-cycle so it is the value seen at the next edge.
   task automatic send(input logic [2:0] op, input int idx, input int val,
                       input int dir);
      req_type r;
      r.operation = op;
      r.index     = idx[MAT_W-1:0];
      r.value     = val[MAT_W-1:0];
      r.direction = dir[2:0];
      if (!no_idle) begin
         while ($urandom_range(99) < 11) begin
            req_valid <= 1'b0;
            @(posedge clock);
         end
      end
      req_valid <= 1'b1;
      req_data  <= r;
      forever begin
         @(negedge clock);
         if (req_ready) break;
      end
      @(posedge clock);
      sb.note_input(r);
      n_req++;
   endtask

   // Drop valid and let every outstanding result drain before touching CSRs
   task automatic wait_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.pending_q.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Write all six registers on consecutive edges
   task automatic program_regs(input int d, input int cxv, input int cyv,
                               input int txv, input int tyv, input int cnt);
      int v [6];
      v[0] = d; v[1] = cxv; v[2] = cyv; v[3] = txv; v[4] = tyv; v[5] = cnt;
      for (int i = 0; i < 6; i++) begin
         csr_we    <= 1'b1;
         csr_index <= CSR_IDX_W'(i);
         csr_wdata <= CSR_DATA_W'(v[i]);
         @(posedge clock);
         sb.set_reg(CSR_IDX_W'(i), CSR_DATA_W'(v[i]));
      end
      csr_we <= 1'b0;
   endtask

   // One configuration: program, load every table entry a query can read,
   // then mostly well-formed queries mixed with rewrites and junk.
   task automatic run_phase(input int d, input int cxv, input int cyv,
                            input int txv, input int tyv, input int cnt,
                            input int nrand);
      int nx, ny, ntx, nty, count, flat, span, r, op;
      wait_idle();
      program_regs(d, cxv, cyv, txv, tyv, cnt);
      n_phase++;
      sb.geometry(nx, ny, ntx, nty, count);
      span = (2*nx/ntx > 1) ? 2*nx/ntx : 1;
      for (int t = 0; t < ntx; t++)
         send(OP_WR_X, t, ($urandom_range(63) << 8) | $urandom_range(span), 0);
      span = (2*ny/nty > 1) ? 2*ny/nty : 1;
      if (d >= 2)
         for (int t = 0; t < nty; t++)
            send(OP_WR_Y, t, ($urandom_range(63) << 8) | $urandom_range(span), 0);
      for (int j = 0; j < nty; j++)
         for (int i = 0; i < ntx; i++)
            send(OP_WR_FLAG, j*MAX_TILES_AXIS + i,
                 ($urandom_range(8191) << 1) | ($urandom_range(9) < 6), 0);
      // Mostly ascending flat indices; a few land beyond the mesh and wrap
      flat = $urandom_range(2);
      span = (2*nx*ny/(count + 1) > 1) ? 2*nx*ny/(count + 1) : 1;
      for (int m = 0; m < count; m++) begin
         send(OP_WR_MAT, m, ($urandom_range(15) == 0) ? $urandom_range(16383) : flat, 0);
         flat += 1 + $urandom_range(span);
      end
      for (int k = 0; k < nrand; k++) begin
         r = $urandom_range(99);
         if (r < 68)
            send(OP_QUERY, (count > 0) ? $urandom_range(count - 1) : $urandom_range(16383),
                 $urandom_range(16383), $urandom_range((d >= 2) ? 3 : 1));
         else if (r < 76)
            send(OP_QUERY, $urandom_range(16383), $urandom_range(16383),
                 $urandom_range(7));
         else if (r < 84) begin
            op = $urandom_range(OP_WR_MAT, OP_WR_X);
            if (op == OP_WR_FLAG)
               send(3'(op), $urandom_range(1023), $urandom_range(16383), $urandom_range(7));
            else if (op == OP_WR_MAT)
               send(3'(op), $urandom_range(16383), $urandom_range(16383), $urandom_range(7));
            else
               send(3'(op), $urandom_range(MAX_TILES_AXIS - 1),
                    ($urandom_range(63) << 8) | $urandom_range(4), $urandom_range(7));
         end else if (r < 92) begin
            op = $urandom_range(OP_WR_FLAG, OP_WR_X);
            send(3'(op), $urandom_range(16383, (op == OP_WR_FLAG) ? 1024 : MAX_TILES_AXIS),
                 $urandom_range(16383), $urandom_range(7));
         end else
            send(3'($urandom_range(7, 5)), $urandom_range(16383), $urandom_range(16383),
                 $urandom_range(7));
      end
   endtask

   // Receiver: check each accepted result, stall at random, and hold off
   // once for a long stretch so the block backs up into req.
   initial begin
      bit      held;
      bit      took;
      rsp_type got;
      held = 1'b0;
      forever begin
         @(negedge clock);
         took = rsp_valid && rsp_ready;
         got  = rsp_data;
         @(posedge clock);
         if (took) begin
            sb.check_result(got);
            n_rsp++;
         end
         if (n_rsp == 150 && !held) begin
            held = 1'b1;
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            rsp_ready <= 1'b1;
         end else begin
            rsp_ready <= (reset == 1'b0) && (no_idle || $urandom_range(99) >= 11);
         end
      end
   end

   // Watchdog: too long without any transaction means the block hung
   always @(negedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet <= 0;
      else quiet <= quiet + 1;
      if (quiet >= QUIET_LIMIT) begin
         $display("timeout after %0d quiet cycles", quiet);
         $display("DONE: errors detected");
         $finish;
      end
   end

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: unused codes, out-of-range writes, query with empty table
      send(3'd5, 16383, 16383, 7);
      send(3'd7, 0, 0, 0);
      send(OP_WR_X, MAX_TILES_AXIS, 16383, 0);
      send(OP_WR_Y, 16383, 0, 0);
      send(OP_WR_FLAG, MAX_TILES_AXIS*MAX_TILES_AXIS, 1, 0);
      send(OP_QUERY, 0, 0, DIR_XN);
      // 4x4 mesh of 2x2 tiles, materials on the diagonal
      wait_idle();
      program_regs(2, 4, 4, 2, 2, 4);
      send(OP_WR_X, 0, 2, 0);
      send(OP_WR_X, 1, 2, 0);
      send(OP_WR_Y, 0, 2, 0);
      send(OP_WR_Y, 1, 2, 0);
      send(OP_WR_FLAG, 0, 1, 0);
      send(OP_WR_FLAG, 1, 0, 0);
      send(OP_WR_FLAG, MAX_TILES_AXIS, 0, 0);
      send(OP_WR_FLAG, MAX_TILES_AXIS + 1, 1, 0);
      for (int m = 0; m < 4; m++) send(OP_WR_MAT, m, 5*m, 0);
      send(OP_QUERY, 4, 0, DIR_XN);        // past material count
      send(OP_QUERY, 0, 0, 4);             // -z in 2D
      send(OP_QUERY, 0, 0, DIR_XN);        // outer edge
      send(OP_QUERY, 3, 0, DIR_XP);        // outer edge
      for (int dir = 0; dir < 4; dir++) begin
         send(OP_QUERY, 1, 0, dir);        // neighbors not in the table
         send(OP_QUERY, 2, 0, dir);
      end

      // Random phases across 1D/2D, odd dimension codes and size extremes
      run_phase(1, 255, 7, 63, 9, 24, 80);
      run_phase(2, 0, 0, 0, 0, 1, 50);
      run_phase(3, 12, 10, 4, 3, 30, 100);
      run_phase(0, 20, 1, 5, 2, 16, 80);
      no_idle = 1'b1;                      // back-to-back stretch
      run_phase(2, 128, 128, 3, 3, 40, 100);
      no_idle = 1'b0;
      run_phase(2, 9, 6, 1, 1, 0, 40);
      run_phase(2, 16, 16, 6, 6, 50, 110);

      wait_idle();
      repeat (DRAIN) @(posedge clock);
      $display("covered %0d req and %0d rsp transactions over %0d configurations",
               n_req, n_rsp, n_phase + 2);
      $display("%0d mismatches, %0d results still owed", sb.mismatches,
               sb.pending_q.size());
      if (sb.mismatches == 0 && sb.pending_q.size() == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule

>>> sim.f
rtl/core/tmnl_pkg.sv
rtl/core/tmnl_div.sv
rtl/core/tmnl_dp.sv
rtl/core/tmnl_ctrl.sv
rtl/core/tiled_mesh_neighbor_lookup.sv
sim/tiled_mesh_neighbor_lookup_test.sv
